// File: rtl/core/spi_buffered_byte_exchanger_unit_assert.svh
// Assertion macros used by the checker of the byte exchanger.
`ifndef SPI_BUFFERED_BYTE_EXCHANGER_UNIT_ASSERT_SVH
`define SPI_BUFFERED_BYTE_EXCHANGER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define SBE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("byte exchanger check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define SBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("byte exchanger check failed");

`endif

// File: rtl/core/sbe_pkg.sv
// Types, codes and defaults shared by the byte exchanger modules.
`default_nettype none

package sbe_pkg;

  // Default ring depths.
  localparam int unsigned RX_DEPTH_DEF = 16;
  localparam int unsigned TX_DEPTH_DEF = 32;

  // Field widths of a result item.
  localparam int unsigned RX_CNT_W = 4;
  localparam int unsigned TX_CNT_W = 5;
  localparam int unsigned ERR_W    = 3;

  // Item kinds; the unused codes behave as status only.
  localparam logic [2:0] KIND_XFER   = 3'd0;
  localparam logic [2:0] KIND_PUT    = 3'd1;
  localparam logic [2:0] KIND_GET    = 3'd2;
  localparam logic [2:0] KIND_CLEAR  = 3'd3;
  localparam logic [2:0] KIND_STATUS = 3'd4;

  // Sticky error bits.
  localparam logic [ERR_W-1:0] ERR_RX_OVERFLOW = 3'b001;
  localparam logic [ERR_W-1:0] ERR_READ_EMPTY  = 3'b010;
  localparam logic [ERR_W-1:0] ERR_TX_FULL     = 3'b100;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]          shift_out_byte;
    logic [7:0]          read_byte;
    logic                read_valid;
    logic [RX_CNT_W-1:0] rx_count;
    logic [TX_CNT_W-1:0] tx_count;
    logic [ERR_W-1:0]    error_flags;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic step;
    logic load;
  } sbe_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/sbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sbe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Storage array and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/sbe_ctrl.sv
// Controller: sequences one item through the store access and the result register.
`default_nettype none

module sbe_ctrl (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output sbe_pkg::sbe_cmd_t cmd_o
);

  import sbe_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  // The result register can take a new result when empty or being drained.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  assign cmd_o.step = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.load = (state_q == ST_READ) && out_free;

  // State and the output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (out_valid_q && out_ready_i) begin
            out_valid_q <= 1'b0;
          end
          if (in_valid_i) begin
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: rtl/core/sbe_dp.sv
// Datapath: ring indices, byte stores, sticky errors and the result register.
`default_nettype none

module sbe_dp #(
  parameter int unsigned RX_DEPTH = sbe_pkg::RX_DEPTH_DEF,
  parameter int unsigned TX_DEPTH = sbe_pkg::TX_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sbe_pkg::sbe_cmd_t  cmd_i,
  input  wire sbe_pkg::in_item_t  in_item_i,
  input  wire logic               cfg_we_i,
  input  wire logic [7:0]         cfg_wdata_i,
  output sbe_pkg::out_item_t      out_item_o
);

  import sbe_pkg::*;

  localparam int unsigned RX_AW = $clog2(RX_DEPTH);
  localparam int unsigned TX_AW = $clog2(TX_DEPTH);
  localparam int unsigned RX_CW = RX_AW + 1;
  localparam int unsigned TX_CW = TX_AW + 1;

  logic [RX_AW-1:0] rx_wr_q, rx_wr_d, rx_rd_q, rx_rd_d, rx_wr_nxt, rx_rd_nxt;
  logic [TX_AW-1:0] tx_wr_q, tx_wr_d, tx_rd_q, tx_rd_d, tx_wr_nxt, tx_rd_nxt;
  logic [ERR_W-1:0] err_q, err_d;
  logic [7:0]       empty_val_q;

  logic             rx_we, rx_re, tx_we, tx_re;
  logic [7:0]       rx_rdata, tx_rdata;

  // Details of the item in flight, held until its result is loaded.
  logic             pend_tx_sel_q, pend_tx_sel_d;
  logic             pend_rx_sel_q, pend_rx_sel_d;
  logic [7:0]       pend_byte_q, pend_byte_d;

  logic [RX_CW-1:0] rx_diff, rx_cnt;
  logic [TX_CW-1:0] tx_diff, tx_cnt;
  out_item_t        out_q;

  // Ring index successors, wrapping at the depth.
  assign rx_wr_nxt = (rx_wr_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_wr_q + 1'b1;
  assign rx_rd_nxt = (rx_rd_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_rd_q + 1'b1;
  assign tx_wr_nxt = (tx_wr_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_wr_q + 1'b1;
  assign tx_rd_nxt = (tx_rd_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_rd_q + 1'b1;

  // Step decode: index updates, store accesses and error updates.
  always_comb begin
    rx_wr_d       = rx_wr_q;
    rx_rd_d       = rx_rd_q;
    tx_wr_d       = tx_wr_q;
    tx_rd_d       = tx_rd_q;
    err_d         = err_q;
    rx_we         = 1'b0;
    rx_re         = 1'b0;
    tx_we         = 1'b0;
    tx_re         = 1'b0;
    pend_tx_sel_d = pend_tx_sel_q;
    pend_rx_sel_d = pend_rx_sel_q;
    pend_byte_d   = pend_byte_q;
    if (cmd_i.step) begin
      pend_tx_sel_d = 1'b0;
      pend_rx_sel_d = 1'b0;
      pend_byte_d   = '0;
      case (in_item_i.kind)
        KIND_XFER: begin
          // A zero byte means nothing was received.
          if (in_item_i.data_byte != 8'd0) begin
            if (rx_wr_nxt == rx_rd_q) begin
              err_d = err_d | ERR_RX_OVERFLOW;
            end else begin
              rx_wr_d = rx_wr_nxt;
              rx_we   = 1'b1;
            end
          end
          if (tx_wr_q != tx_rd_q) begin
            tx_rd_d       = tx_rd_nxt;
            tx_re         = 1'b1;
            pend_tx_sel_d = 1'b1;
          end
        end
        KIND_PUT: begin
          if (tx_wr_nxt == tx_rd_q) begin
            err_d = err_d | ERR_TX_FULL;
          end else begin
            tx_wr_d = tx_wr_nxt;
            tx_we   = 1'b1;
          end
        end
        KIND_GET: begin
          if (rx_wr_q == rx_rd_q) begin
            err_d       = err_d | ERR_READ_EMPTY;
            pend_byte_d = empty_val_q;
          end else begin
            rx_rd_d       = rx_rd_nxt;
            rx_re         = 1'b1;
            pend_rx_sel_d = 1'b1;
          end
        end
        KIND_CLEAR: begin
          err_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_wr_q       <= '0;
      rx_rd_q       <= '0;
      tx_wr_q       <= '0;
      tx_rd_q       <= '0;
      err_q         <= '0;
      empty_val_q   <= '0;
      pend_tx_sel_q <= 1'b0;
      pend_rx_sel_q <= 1'b0;
    end else begin
      rx_wr_q       <= rx_wr_d;
      rx_rd_q       <= rx_rd_d;
      tx_wr_q       <= tx_wr_d;
      tx_rd_q       <= tx_rd_d;
      err_q         <= err_d;
      pend_tx_sel_q <= pend_tx_sel_d;
      pend_rx_sel_q <= pend_rx_sel_d;
      if (cfg_we_i) begin
        empty_val_q <= cfg_wdata_i;
      end
    end
  end

  // Byte held for a get on an empty ring.
  always_ff @(posedge clk_i) begin
    pend_byte_q <= pend_byte_d;
  end

  // Byte stores.
  sbe_ram #(
    .Width (8),
    .Depth (RX_DEPTH)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_wr_nxt),
    .wdata_i (in_item_i.data_byte),
    .re_i    (rx_re),
    .raddr_i (rx_rd_nxt),
    .rdata_o (rx_rdata)
  );

  sbe_ram #(
    .Width (8),
    .Depth (TX_DEPTH)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_wr_nxt),
    .wdata_i (in_item_i.data_byte),
    .re_i    (tx_re),
    .raddr_i (tx_rd_nxt),
    .rdata_o (tx_rdata)
  );

  // Ring fill counts; a negative difference wraps by the depth.
  assign rx_diff = {1'b0, rx_wr_q} - {1'b0, rx_rd_q};
  assign tx_diff = {1'b0, tx_wr_q} - {1'b0, tx_rd_q};
  assign rx_cnt  = (rx_wr_q >= rx_rd_q) ? rx_diff : rx_diff + RX_CW'(RX_DEPTH);
  assign tx_cnt  = (tx_wr_q >= tx_rd_q) ? tx_diff : tx_diff + TX_CW'(TX_DEPTH);

  // Result register, loaded once the store data has arrived.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q.shift_out_byte <= pend_tx_sel_q ? tx_rdata : 8'd0;
      out_q.read_byte      <= pend_rx_sel_q ? rx_rdata : pend_byte_q;
      out_q.read_valid     <= pend_rx_sel_q;
      out_q.rx_count       <= RX_CNT_W'(rx_cnt);
      out_q.tx_count       <= TX_CNT_W'(tx_cnt);
      out_q.error_flags    <= err_q;
    end
  end

  assign out_item_o = out_q;

endmodule

`default_nettype wire

// File: rtl/core/spi_buffered_byte_exchanger_unit.sv
// Top level of the buffered SPI byte exchanger.
// Each accepted item is decoded and the ring indices and byte stores are
// updated in the accept cycle; the registered transmit or receive store read
// returns in the next cycle, and the result is loaded into the output register
// once that register is free. in_ready_o is low from each transfer until its
// result is loaded, so no new item is taken before that. The output register
// lets a new item be taken while a finished result still waits; a result that
// is not taken holds the controller in its read state. The configuration
// register may be written in any cycle and takes effect for the next item.
// Both byte stores come up unwritten; no clearing pass is run.
`default_nettype none

module spi_buffered_byte_exchanger_unit #(
  parameter int unsigned RX_DEPTH = sbe_pkg::RX_DEPTH_DEF,
  parameter int unsigned TX_DEPTH = sbe_pkg::TX_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire sbe_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output sbe_pkg::out_item_t      out_item_o,
  input  wire logic               cfg_we_i,
  input  wire logic [7:0]         cfg_wdata_i
);

  import sbe_pkg::*;

  sbe_cmd_t cmd;

  // Sequencing of items and results.
  sbe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Rings, errors and the result register.
  sbe_dp #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// File: rtl/core/sbe_checker.sv
// Port-level checker for the byte exchanger and its bind to the top level.
`default_nettype none
`include "spi_buffered_byte_exchanger_unit_assert.svh"

module sbe_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire sbe_pkg::out_item_t out_item_i
);

  import sbe_pkg::*;

  // A stalled result stays valid and unchanged.
  `SBE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_item_i))

  // Items are taken one at a time, so ready drops after each transfer.
  `SBE_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // After a transfer in, a result is always on offer, whether a new one or one still stalled.
  `SBE_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, in_valid_i && in_ready_i, ##1 out_valid_i)

  // Only a get returns a popped byte, and a get shifts nothing out.
  `SBE_ASSERT_NOW(a_get_no_shift, clk_i, rst_ni, out_valid_i && out_item_i.read_valid, out_item_i.shift_out_byte == 8'd0)

endmodule

bind spi_buffered_byte_exchanger_unit sbe_checker u_sbe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_i  (out_item_o)
);

`default_nettype wire
